// ===== design/tcs_pkg.sv =====
// Package for the tilt cursor selector: widths, codes, register layout and
// the item-to-ASCII lookup. No dependencies; every other file uses it.
package tcs_pkg;

  localparam int MAX_TEXT  = 63;
  localparam int TEXT_AW   = $clog2(MAX_TEXT);
  localparam int CNT_W     = $clog2(MAX_TEXT + 1);
  localparam int TIME_BITS = 48;
  localparam int LVL_W     = 15;
  localparam int DLY_W     = 24;
  localparam int ACC_W     = 16;
  localparam int CUR_W     = 7;
  localparam int CHAR_W    = 7;
  localparam int POS_W     = 6;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 24;

  localparam logic [CUR_W-1:0] IDX_LAST   = 7'd97;
  localparam logic [CUR_W-1:0] IDX_DEL    = 7'd95;
  localparam logic [CUR_W-1:0] IDX_OK     = 7'd96;
  localparam logic [CUR_W-1:0] IDX_CANCEL = 7'd97;
  localparam logic [CUR_W-1:0] CURSOR_RST = 7'd3;

  localparam logic [LVL_W-1:0] SIDE_START_RST = 15'd1147;
  localparam logic [LVL_W-1:0] SIDE_STOP_RST  = 15'd737;
  localparam logic [LVL_W-1:0] FWD_START_RST  = 15'd1966;
  localparam logic [LVL_W-1:0] FWD_STOP_RST   = 15'd1311;
  localparam logic [DLY_W-1:0] FIRST_DLY_RST  = 24'd450000;
  localparam logic [DLY_W-1:0] REPEAT_RST     = 24'd200000;

  typedef enum logic [1:0] {
    REQ_TILT     = 2'd0,
    REQ_ACTIVATE = 2'd1,
    REQ_READ     = 2'd2,
    REQ_NOP      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_OK     = 2'd2,
    ACT_CANCEL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SIDE_START = 3'd0,
    CFG_SIDE_STOP  = 3'd1,
    CFG_FWD_START  = 3'd2,
    CFG_FWD_STOP   = 3'd3,
    CFG_FIRST_DLY  = 3'd4,
    CFG_REPEAT     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0] side_start;
    logic [LVL_W-1:0] side_stop;
    logic [LVL_W-1:0] fwd_start;
    logic [LVL_W-1:0] fwd_stop;
    logic [DLY_W-1:0] first_delay;
    logic [DLY_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic             moved;
    logic [CUR_W-1:0] cursor;
  } tilt_res_t;

  typedef struct packed {
    action_t           action;
    logic [CNT_W-1:0]  text_length;
    logic [CHAR_W-1:0] char_code;
  } text_res_t;

  // Symbols for items 62 to 94, in ASCII
  localparam logic [CHAR_W-1:0] SYM_TABLE [0:32] = '{
    7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39,
    7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47,
    7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd91,
    7'd92, 7'd93, 7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125,
    7'd126
  };

  // Hysteresis compare with strict bounds: plus above +lvl, minus below -lvl
  function automatic dir_t axis_dir(input logic signed [ACC_W-1:0] a,
                                    input logic [LVL_W-1:0] lvl);
    logic signed [ACC_W:0] ax;
    logic signed [ACC_W:0] lp;
    ax = {a[ACC_W-1], a};
    lp = {2'b00, lvl};
    if (ax > lp) begin
      return DIR_PLUS;
    end else if (ax < -lp) begin
      return DIR_MINUS;
    end
    return DIR_NONE;
  endfunction

  function automatic logic [CHAR_W-1:0] item_code(input logic [CUR_W-1:0] idx);
    logic [CUR_W-1:0] sym;
    sym = idx - 7'd62;
    if (idx < 7'd26) begin
      return idx + 7'd97;
    end else if (idx < 7'd52) begin
      return idx + 7'd39;
    end else if (idx < 7'd62) begin
      return idx - 7'd4;
    end else if (idx < 7'd95) begin
      return SYM_TABLE[sym[5:0]];
    end
    return '0;
  endfunction

endpackage

// ===== design/tcs_if.sv =====
// Channel interfaces of the tilt cursor selector: request, result and
// register write. Depends on tcs_pkg for the field widths.
interface tcs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           req_type;
  logic signed [tcs_pkg::ACC_W-1:0]     side_accel;
  logic signed [tcs_pkg::ACC_W-1:0]     fwd_accel;
  logic [tcs_pkg::TIME_BITS-1:0]        now_us;
  logic [tcs_pkg::POS_W-1:0]            read_position;

  modport source (output valid, req_type, side_accel, fwd_accel, now_us, read_position,
                  input ready);
  modport sink (input valid, req_type, side_accel, fwd_accel, now_us, read_position,
                output ready);
endinterface

interface tcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          moved;
  logic [tcs_pkg::CUR_W-1:0]     cursor_index;
  logic [1:0]                    action;
  logic [tcs_pkg::CNT_W-1:0]     text_length;
  logic [tcs_pkg::CHAR_W-1:0]    char_code;

  modport source (output valid, moved, cursor_index, action, text_length, char_code,
                  input ready);
  modport sink (input valid, moved, cursor_index, action, text_length, char_code,
                output ready);
endinterface

interface tcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcs_pkg::CFG_AW-1:0]    reg_index;
  logic [tcs_pkg::CFG_DW-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/tcs_cfg_regs.sv =====
// Configuration register bank: tilt levels and repeat timing.
// Depends on tcs_pkg and tcs_cfg_if.
module tcs_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  tcs_cfg_if.sink           cfg_if,
  output tcs_pkg::cfg_t     cfg
);

  tcs_pkg::cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_start    <= tcs_pkg::SIDE_START_RST;
      cfg_r.side_stop     <= tcs_pkg::SIDE_STOP_RST;
      cfg_r.fwd_start     <= tcs_pkg::FWD_START_RST;
      cfg_r.fwd_stop      <= tcs_pkg::FWD_STOP_RST;
      cfg_r.first_delay   <= tcs_pkg::FIRST_DLY_RST;
      cfg_r.repeat_period <= tcs_pkg::REPEAT_RST;
    end else if (cfg_if.valid) begin
      unique case (tcs_pkg::cfg_idx_t'(cfg_if.reg_index))
        tcs_pkg::CFG_SIDE_START: cfg_r.side_start <= cfg_if.wr_data[tcs_pkg::LVL_W-1:0];
        tcs_pkg::CFG_SIDE_STOP:  cfg_r.side_stop  <= cfg_if.wr_data[tcs_pkg::LVL_W-1:0];
        tcs_pkg::CFG_FWD_START:  cfg_r.fwd_start  <= cfg_if.wr_data[tcs_pkg::LVL_W-1:0];
        tcs_pkg::CFG_FWD_STOP:   cfg_r.fwd_stop   <= cfg_if.wr_data[tcs_pkg::LVL_W-1:0];
        tcs_pkg::CFG_FIRST_DLY:  cfg_r.first_delay   <= cfg_if.wr_data[tcs_pkg::DLY_W-1:0];
        tcs_pkg::CFG_REPEAT:     cfg_r.repeat_period <= cfg_if.wr_data[tcs_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/tcs_tilt.sv =====
// Tilt unit: hysteresis on both axes, jump to OK/DEL, typematic cursor steps.
// Holds the cursor and axis state. Depends on tcs_pkg.
module tcs_tilt (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step_en,
  input  logic signed [tcs_pkg::ACC_W-1:0]     side_accel,
  input  logic signed [tcs_pkg::ACC_W-1:0]     fwd_accel,
  input  logic [tcs_pkg::TIME_BITS-1:0]        now_us,
  input  tcs_pkg::cfg_t                        cfg,
  output tcs_pkg::tilt_res_t                   res,
  output logic [tcs_pkg::CUR_W-1:0]            cursor_cur
);

  logic [tcs_pkg::CUR_W-1:0]     cursor_r, cursor_nxt;
  tcs_pkg::dir_t                 fwd_dir_r, fwd_dir_nxt;
  tcs_pkg::dir_t                 side_dir_r, side_dir_nxt;
  logic [tcs_pkg::TIME_BITS-1:0] next_step_r, next_step_nxt;

  tcs_pkg::dir_t                 fwd_v;
  tcs_pkg::dir_t                 side_raw;
  tcs_pkg::dir_t                 side_d;
  logic [tcs_pkg::TIME_BITS-1:0] due_first;
  logic [tcs_pkg::TIME_BITS-1:0] due_repeat;
  logic [tcs_pkg::CUR_W-1:0]     cursor_inc;
  logic [tcs_pkg::CUR_W-1:0]     cursor_dec;
  logic                          step;
  logic                          moved;

  assign fwd_v = tcs_pkg::axis_dir(fwd_accel, (fwd_dir_r != tcs_pkg::DIR_NONE) ?
                                   cfg.fwd_stop : cfg.fwd_start);
  assign side_raw = tcs_pkg::axis_dir(side_accel, (side_dir_r != tcs_pkg::DIR_NONE) ?
                                      cfg.side_stop : cfg.side_start);
  // Positive sideways tilt moves towards lower indices
  assign side_d = (side_raw == tcs_pkg::DIR_PLUS)  ? tcs_pkg::DIR_MINUS :
                  (side_raw == tcs_pkg::DIR_MINUS) ? tcs_pkg::DIR_PLUS  : tcs_pkg::DIR_NONE;

  assign due_first  = now_us + {{(tcs_pkg::TIME_BITS-tcs_pkg::DLY_W){1'b0}}, cfg.first_delay};
  assign due_repeat = now_us + {{(tcs_pkg::TIME_BITS-tcs_pkg::DLY_W){1'b0}}, cfg.repeat_period};
  assign cursor_inc = (cursor_r == tcs_pkg::IDX_LAST) ? '0 : cursor_r + 7'd1;
  assign cursor_dec = (cursor_r == '0) ? tcs_pkg::IDX_LAST : cursor_r - 7'd1;

  always_comb begin
    cursor_nxt    = cursor_r;
    fwd_dir_nxt   = fwd_dir_r;
    side_dir_nxt  = side_dir_r;
    next_step_nxt = next_step_r;
    moved         = 1'b0;
    step          = 1'b0;
    if (fwd_v != tcs_pkg::DIR_NONE) begin
      side_dir_nxt  = tcs_pkg::DIR_NONE;
      next_step_nxt = '0;
      if (fwd_v != fwd_dir_r) begin
        fwd_dir_nxt = fwd_v;
        cursor_nxt  = (fwd_v == tcs_pkg::DIR_PLUS) ? tcs_pkg::IDX_OK : tcs_pkg::IDX_DEL;
        moved       = 1'b1;
      end
    end else begin
      fwd_dir_nxt = tcs_pkg::DIR_NONE;
      if (side_d == tcs_pkg::DIR_NONE) begin
        side_dir_nxt  = tcs_pkg::DIR_NONE;
        next_step_nxt = '0;
      end else if (side_d != side_dir_r) begin
        side_dir_nxt  = side_d;
        next_step_nxt = due_first;
        step          = 1'b1;
      end else if (!(now_us < next_step_r)) begin
        next_step_nxt = due_repeat;
        step          = 1'b1;
      end
      if (step) begin
        cursor_nxt = (side_d == tcs_pkg::DIR_PLUS) ? cursor_inc : cursor_dec;
        moved      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= tcs_pkg::CURSOR_RST;
      fwd_dir_r   <= tcs_pkg::DIR_NONE;
      side_dir_r  <= tcs_pkg::DIR_NONE;
      next_step_r <= '0;
    end else if (step_en) begin
      cursor_r    <= cursor_nxt;
      fwd_dir_r   <= fwd_dir_nxt;
      side_dir_r  <= side_dir_nxt;
      next_step_r <= next_step_nxt;
    end
  end

  assign res.moved  = moved;
  assign res.cursor = cursor_nxt;
  assign cursor_cur = cursor_r;

endmodule

// ===== design/tcs_text.sv =====
// Text buffer: activate handling (append, delete, OK, CANCEL) and reads.
// Holds the character memory and the fill count. Depends on tcs_pkg.
module tcs_text (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_issue,
  input  logic [tcs_pkg::POS_W-1:0]           rd_addr,
  input  logic                                step_en,
  input  tcs_pkg::req_t                       req,
  input  logic [tcs_pkg::CUR_W-1:0]           cursor,
  input  logic [tcs_pkg::POS_W-1:0]           pos,
  output tcs_pkg::text_res_t                  res
);

  logic [tcs_pkg::CHAR_W-1:0]  text_mem [tcs_pkg::MAX_TEXT];
  logic [tcs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [tcs_pkg::CHAR_W-1:0]  rd_q_r;
  logic                        fwd_hit_r;
  logic [tcs_pkg::CHAR_W-1:0]  fwd_data_r;

  logic [tcs_pkg::TEXT_AW-1:0] wr_addr;
  logic [tcs_pkg::TEXT_AW-1:0] rd_idx;
  logic                        rd_ok;
  logic                        wr_en;
  logic [tcs_pkg::CHAR_W-1:0]  ch;
  logic [tcs_pkg::CHAR_W-1:0]  rd_data;
  tcs_pkg::action_t            action;

  assign wr_addr = count_r[tcs_pkg::TEXT_AW-1:0];
  assign rd_idx  = rd_addr[tcs_pkg::TEXT_AW-1:0];
  assign rd_ok   = rd_addr < tcs_pkg::POS_W'(tcs_pkg::MAX_TEXT);
  // A write in the cycle of the read address is not yet in the array
  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

  always_comb begin
    action    = tcs_pkg::ACT_NONE;
    ch        = '0;
    count_nxt = count_r;
    wr_en     = 1'b0;
    unique case (req)
      tcs_pkg::REQ_ACTIVATE: begin
        priority if (cursor == tcs_pkg::IDX_OK) begin
          action = tcs_pkg::ACT_OK;
        end else if (cursor == tcs_pkg::IDX_CANCEL) begin
          action = tcs_pkg::ACT_CANCEL;
        end else if (cursor == tcs_pkg::IDX_DEL) begin
          action = tcs_pkg::ACT_TEXT;
          if (count_r != '0) begin
            count_nxt = count_r - tcs_pkg::CNT_W'(1);
          end
        end else begin
          action = tcs_pkg::ACT_TEXT;
          if (count_r < tcs_pkg::CNT_W'(tcs_pkg::MAX_TEXT)) begin
            ch        = tcs_pkg::item_code(cursor);
            wr_en     = 1'b1;
            count_nxt = count_r + tcs_pkg::CNT_W'(1);
          end
        end
      end
      tcs_pkg::REQ_READ: begin
        if (pos < count_r) begin
          ch = rd_data;
        end
      end
      tcs_pkg::REQ_TILT, tcs_pkg::REQ_NOP: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step_en && wr_en) begin
      text_mem[wr_addr] <= ch;
    end
    if (rd_issue && rd_ok) begin
      rd_q_r <= text_mem[rd_idx];
    end
    if (rd_issue) begin
      fwd_hit_r  <= step_en && wr_en && (wr_addr == rd_idx);
      fwd_data_r <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step_en) begin
      count_r <= count_nxt;
    end
  end

  assign res.action      = action;
  assign res.text_length = count_nxt;
  assign res.char_code   = ch;

endmodule

// ===== design/tilt_cursor_selector.sv =====
// Channel   | Dir | Content
// in_if     | in  | req_type, side_accel, fwd_accel, now_us, read_position
// out_if    | out | moved, cursor_index, action, text_length, char_code
// cfg_if    | in  | reg_index, wr_data (levels and repeat timing)
//
// One request per clock while the result side is not stalled: input register, one
// pass of compare/update logic, then the result register that drives out_if.
// The text memory read is issued on the input transfer and registered.
// Synchronous active-low reset: cursor 3, no tilt direction, empty text.
// A stalled result holds; a new request is still taken while the input
// register is free or moving into the result register.
module tilt_cursor_selector (
  input  logic       clk,
  input  logic       rst_n,
  tcs_in_if.sink     in_if,
  tcs_out_if.source  out_if,
  tcs_cfg_if.sink    cfg_if
);

  tcs_pkg::cfg_t       cfg;
  tcs_pkg::tilt_res_t  tilt_res;
  tcs_pkg::text_res_t  text_res;
  logic [tcs_pkg::CUR_W-1:0] tilt_cur;

  logic                                 s1_v_r;
  tcs_pkg::req_t                        s1_req_r;
  logic signed [tcs_pkg::ACC_W-1:0]     s1_side_r;
  logic signed [tcs_pkg::ACC_W-1:0]     s1_fwd_r;
  logic [tcs_pkg::TIME_BITS-1:0]        s1_now_r;
  logic [tcs_pkg::POS_W-1:0]            s1_pos_r;

  logic                                 out_v_r;
  logic                                 out_moved_r;
  logic [tcs_pkg::CUR_W-1:0]            out_cursor_r;
  tcs_pkg::action_t                     out_action_r;
  logic [tcs_pkg::CNT_W-1:0]            out_len_r;
  logic [tcs_pkg::CHAR_W-1:0]           out_char_r;

  logic in_xfer;
  logic s1_adv;
  logic s1_tilt;
  logic tilt_moved;
  logic [tcs_pkg::CUR_W-1:0] cursor_sel;

  assign s1_adv  = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_xfer = in_if.valid && in_if.ready;
  assign s1_tilt = s1_req_r == tcs_pkg::REQ_TILT;

  tcs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  tcs_tilt u_tilt (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_adv && s1_tilt),
    .side_accel (s1_side_r),
    .fwd_accel  (s1_fwd_r),
    .now_us     (s1_now_r),
    .cfg        (cfg),
    .res        (tilt_res),
    .cursor_cur (tilt_cur)
  );

  tcs_text u_text (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_issue (in_xfer),
    .rd_addr  (in_if.read_position),
    .step_en  (s1_adv),
    .req      (s1_req_r),
    .cursor   (tilt_cur),
    .pos      (s1_pos_r),
    .res      (text_res)
  );

  assign tilt_moved = s1_tilt && tilt_res.moved;
  assign cursor_sel = s1_tilt ? tilt_res.cursor : tilt_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= tcs_pkg::req_t'(in_if.req_type);
      s1_side_r <= in_if.side_accel;
      s1_fwd_r  <= in_if.fwd_accel;
      s1_now_r  <= in_if.now_us;
      s1_pos_r  <= in_if.read_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_moved_r  <= tilt_moved;
      out_cursor_r <= cursor_sel;
      out_action_r <= text_res.action;
      out_len_r    <= text_res.text_length;
      out_char_r   <= text_res.char_code;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.moved        = out_moved_r;
  assign out_if.cursor_index = out_cursor_r;
  assign out_if.action       = out_action_r;
  assign out_if.text_length  = out_len_r;
  assign out_if.char_code    = out_char_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r)
    else $error("advanced request did not reach the result register");

  a_moved_only_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && tilt_moved) |-> (s1_req_r == tcs_pkg::REQ_TILT))
    else $error("cursor reported moved on a non-tilt request");

  a_action_only_activate: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && text_res.action != tcs_pkg::ACT_NONE) |-> (s1_req_r == tcs_pkg::REQ_ACTIVATE))
    else $error("action reported on a non-activate request");

  a_cursor_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_tilt) |=> $stable(tilt_cur))
    else $error("cursor changed on a non-tilt request");

endmodule

// ===== dv/tilt_cursor_selector_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tilt_cursor_selector: directed and random requests
// against a cycle-free prediction of cursor, typematic repeat and text store.
// Depends on tcs_pkg and the channel interfaces in tcs_if.
module tilt_cursor_selector_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 4;
  // Symbols for items 62 to 94, first character in the top byte
  localparam logic [8*33-1:0] SYMBOL_ROW = " !\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    tcs_pkg::req_t                    kind;
    logic signed [tcs_pkg::ACC_W-1:0] side;
    logic signed [tcs_pkg::ACC_W-1:0] fwd;
    logic [tcs_pkg::TIME_BITS-1:0]    now;
    logic [tcs_pkg::POS_W-1:0]        pos;
  } sel_req_t;

  typedef struct {
    logic                       moved;
    logic [tcs_pkg::CUR_W-1:0]  cursor;
    tcs_pkg::action_t           action;
    logic [tcs_pkg::CNT_W-1:0]  len;
    logic [tcs_pkg::CHAR_W-1:0] ch;
  } sel_res_t;

  logic clk;
  logic rst_n;

  tcs_in_if  in_ch();
  tcs_out_if out_ch();
  tcs_cfg_if cfg_ch();

  tilt_cursor_selector uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predicted block state
  tcs_pkg::cfg_t                 sel_cfg;
  logic [tcs_pkg::CUR_W-1:0]     sel_cursor;
  tcs_pkg::dir_t                 sel_side_dir;
  tcs_pkg::dir_t                 sel_fwd_dir;
  logic [tcs_pkg::TIME_BITS-1:0] sel_next_step;
  logic [tcs_pkg::CHAR_W-1:0]    sel_text [0:tcs_pkg::MAX_TEXT-1];
  logic [tcs_pkg::CNT_W-1:0]     sel_count;

  sel_res_t pending_selections [$];

  logic [tcs_pkg::TIME_BITS-1:0] stim_now;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int repeat_steps  = 0;
  int full_refusals = 0;
  int burst_left    = 1;
  bit no_gaps       = 1'b0;
  int hold_req      = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic tcs_pkg::dir_t tilt_dir(input logic signed [tcs_pkg::ACC_W-1:0] a,
                                             input logic [tcs_pkg::LVL_W-1:0] start_lvl,
                                             input logic [tcs_pkg::LVL_W-1:0] stop_lvl,
                                             input bit held);
    int av;
    int lv;
    av = a;
    lv = held ? stop_lvl : start_lvl;
    if (av > lv) return tcs_pkg::DIR_PLUS;
    if (av < -lv) return tcs_pkg::DIR_MINUS;
    return tcs_pkg::DIR_NONE;
  endfunction

  function automatic logic [tcs_pkg::CUR_W-1:0] step_cursor(
      input logic [tcs_pkg::CUR_W-1:0] c, input tcs_pkg::dir_t d);
    if (d == tcs_pkg::DIR_PLUS) return (c == tcs_pkg::IDX_LAST) ? '0 : c + 1'b1;
    return (c == '0) ? tcs_pkg::IDX_LAST : c - 1'b1;
  endfunction

  function automatic logic [tcs_pkg::CHAR_W-1:0] ascii_of(
      input logic [tcs_pkg::CUR_W-1:0] idx);
    int k;
    k = idx;
    if (k < 26) return 7'(97 + k);
    if (k < 52) return 7'(65 + k - 26);
    if (k < 62) return 7'(48 + k - 52);
    if (k < 95) return SYMBOL_ROW[8*(32-(k-62)) +: 7];
    return '0;
  endfunction

  task automatic compute_selection(input sel_req_t rq, output sel_res_t rs);
    tcs_pkg::dir_t fv;
    tcs_pkg::dir_t raw;
    tcs_pkg::dir_t sd;
    rs.moved  = 1'b0;
    rs.action = tcs_pkg::ACT_NONE;
    rs.ch     = '0;
    case (rq.kind)
      tcs_pkg::REQ_TILT: begin
        fv = tilt_dir(rq.fwd, sel_cfg.fwd_start, sel_cfg.fwd_stop,
                      sel_fwd_dir != tcs_pkg::DIR_NONE);
        if (fv != tcs_pkg::DIR_NONE) begin
          sel_side_dir  = tcs_pkg::DIR_NONE;
          sel_next_step = '0;
          if (fv != sel_fwd_dir) begin
            sel_fwd_dir = fv;
            sel_cursor  = (fv == tcs_pkg::DIR_PLUS) ? tcs_pkg::IDX_OK : tcs_pkg::IDX_DEL;
            rs.moved    = 1'b1;
          end
        end else begin
          sel_fwd_dir = tcs_pkg::DIR_NONE;
          raw = tilt_dir(rq.side, sel_cfg.side_start, sel_cfg.side_stop,
                         sel_side_dir != tcs_pkg::DIR_NONE);
          // positive sideways acceleration steps the cursor down
          if (raw == tcs_pkg::DIR_PLUS) sd = tcs_pkg::DIR_MINUS;
          else if (raw == tcs_pkg::DIR_MINUS) sd = tcs_pkg::DIR_PLUS;
          else sd = tcs_pkg::DIR_NONE;
          if (sd == tcs_pkg::DIR_NONE) begin
            sel_side_dir  = tcs_pkg::DIR_NONE;
            sel_next_step = '0;
          end else if (sd != sel_side_dir) begin
            sel_side_dir  = sd;
            sel_next_step = rq.now + sel_cfg.first_delay;
            rs.moved      = 1'b1;
          end else if (rq.now >= sel_next_step) begin
            sel_next_step = rq.now + sel_cfg.repeat_period;
            rs.moved      = 1'b1;
            repeat_steps++;
          end
          if (rs.moved) sel_cursor = step_cursor(sel_cursor, sd);
        end
      end
      tcs_pkg::REQ_ACTIVATE: begin
        if (sel_cursor == tcs_pkg::IDX_OK) begin
          rs.action = tcs_pkg::ACT_OK;
        end else if (sel_cursor == tcs_pkg::IDX_CANCEL) begin
          rs.action = tcs_pkg::ACT_CANCEL;
        end else if (sel_cursor == tcs_pkg::IDX_DEL) begin
          if (sel_count != 0) sel_count--;
          rs.action = tcs_pkg::ACT_TEXT;
        end else begin
          if (sel_count < tcs_pkg::MAX_TEXT) begin
            rs.ch = ascii_of(sel_cursor);
            sel_text[sel_count] = rs.ch;
            sel_count++;
          end else begin
            full_refusals++;
          end
          rs.action = tcs_pkg::ACT_TEXT;
        end
      end
      tcs_pkg::REQ_READ: begin
        if (rq.pos < sel_count) rs.ch = sel_text[rq.pos];
      end
      default: ;
    endcase
    rs.cursor = sel_cursor;
    rs.len    = sel_count;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [tcs_pkg::ACC_W-1:0] to_accel(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[tcs_pkg::ACC_W-1:0];
  endfunction

  // Magnitude biased towards the edges of a threshold
  function automatic int near_level(input int lvl);
    case ($urandom_range(0, 6))
      0: return lvl;
      1: return lvl + 1;
      2: return (lvl > 0) ? lvl - 1 : 0;
      3: return $urandom_range(0, lvl);
      4: return lvl + $urandom_range(1, 2000);
      5: return 32768;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  function automatic logic [tcs_pkg::TIME_BITS-1:0] next_time();
    int sc;
    logic [63:0] r;
    sc = (sel_cfg.first_delay > sel_cfg.repeat_period) ? sel_cfg.first_delay
                                                       : sel_cfg.repeat_period;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 19))
      0, 1:          ;
      2, 3, 4, 5:    stim_now = stim_now + $urandom_range(0, sc / 3 + 1);
      6, 7, 8, 9, 10, 11, 12, 13, 14, 15:
                     stim_now = stim_now + $urandom_range(sc / 2, sc + sc / 4 + 1);
      16, 17:        stim_now = stim_now + $urandom_range(0, 1000000);
      18:            stim_now = r[tcs_pkg::TIME_BITS-1:0];
      default:       stim_now = {tcs_pkg::TIME_BITS{1'b1}} - $urandom_range(0, sc + 10);
    endcase
    return stim_now;
  endfunction

  task automatic pace_sender();
    int gap;
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 30);
      end
    end
  endtask

  task automatic send_request(input sel_req_t rq);
    sel_res_t rs;
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= rq.kind;
    in_ch.side_accel    <= rq.side;
    in_ch.fwd_accel     <= rq.fwd;
    in_ch.now_us        <= rq.now;
    in_ch.read_position <= rq.pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    compute_selection(rq, rs);
    pending_selections = {pending_selections, rs};
    items_sent++;
    pace_sender();
  endtask

  task automatic send_tilt(input int side, input int fwd,
                           input logic [tcs_pkg::TIME_BITS-1:0] now);
    sel_req_t rq;
    rq.kind = tcs_pkg::REQ_TILT;
    rq.side = to_accel(side);
    rq.fwd  = to_accel(fwd);
    rq.now  = now;
    rq.pos  = tcs_pkg::POS_W'($urandom());
    send_request(rq);
  endtask

  // Non-tilt request: the acceleration and time fields carry noise
  task automatic send_cmd(input tcs_pkg::req_t kind, input int pos);
    sel_req_t rq;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    rq.kind = kind;
    rq.side = tcs_pkg::ACC_W'($urandom());
    rq.fwd  = tcs_pkg::ACC_W'($urandom());
    rq.now  = r[tcs_pkg::TIME_BITS-1:0];
    rq.pos  = pos[tcs_pkg::POS_W-1:0];
    send_request(rq);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_selections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tcs_pkg::cfg_idx_t idx,
                           input logic [tcs_pkg::CFG_DW-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      tcs_pkg::CFG_SIDE_START: sel_cfg.side_start    = data[tcs_pkg::LVL_W-1:0];
      tcs_pkg::CFG_SIDE_STOP:  sel_cfg.side_stop     = data[tcs_pkg::LVL_W-1:0];
      tcs_pkg::CFG_FWD_START:  sel_cfg.fwd_start     = data[tcs_pkg::LVL_W-1:0];
      tcs_pkg::CFG_FWD_STOP:   sel_cfg.fwd_stop      = data[tcs_pkg::LVL_W-1:0];
      tcs_pkg::CFG_FIRST_DLY:  sel_cfg.first_delay   = data;
      tcs_pkg::CFG_REPEAT:     sel_cfg.repeat_period = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_settings(input int ss, input int sp, input int fs, input int fp,
                                input int fd, input int rp);
    wait_for_results();
    write_reg(tcs_pkg::CFG_SIDE_START, tcs_pkg::CFG_DW'(ss));
    write_reg(tcs_pkg::CFG_SIDE_STOP, tcs_pkg::CFG_DW'(sp));
    write_reg(tcs_pkg::CFG_FWD_START, tcs_pkg::CFG_DW'(fs));
    write_reg(tcs_pkg::CFG_FWD_STOP, tcs_pkg::CFG_DW'(fp));
    write_reg(tcs_pkg::CFG_FIRST_DLY, tcs_pkg::CFG_DW'(fd));
    write_reg(tcs_pkg::CFG_REPEAT, tcs_pkg::CFG_DW'(rp));
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed tilt holds and edits, with some raw noise
  task automatic run_random(input int n);
    int start_cnt;
    int len;
    int mag;
    int fq;
    int sgn;
    sel_req_t rq;
    logic [63:0] r;
    start_cnt = items_sent;
    while (items_sent - start_cnt < n) begin
      fq  = (sel_cfg.fwd_start < sel_cfg.fwd_stop) ? sel_cfg.fwd_start : sel_cfg.fwd_stop;
      sgn = $urandom_range(0, 1) ? -1 : 1;
      case ($urandom_range(0, 99)) inside
        [0:39]: begin
          len = $urandom_range(2, 12);
          for (int i = 0; i < len; i++) begin
            if (i == 0) mag = near_level(sel_cfg.side_start);
            else if ($urandom_range(0, 9) < 7) mag = sel_cfg.side_stop + $urandom_range(1, 3000);
            else mag = near_level(sel_cfg.side_stop);
            send_tilt(sgn * mag, ($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, fq),
                      next_time());
          end
        end
        [40:54]: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            if (i == 0) mag = near_level(sel_cfg.fwd_start);
            else if ($urandom_range(0, 9) < 7) mag = sel_cfg.fwd_stop + $urandom_range(1, 3000);
            else mag = near_level(sel_cfg.fwd_stop);
            send_tilt($signed(tcs_pkg::ACC_W'($urandom())), sgn * mag, next_time());
          end
          if ($urandom_range(0, 1)) send_tilt(0, 0, next_time());
        end
        [55:74]: begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            send_cmd(tcs_pkg::REQ_ACTIVATE, $urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0) send_cmd(tcs_pkg::REQ_READ, $urandom_range(0, 63));
          end
        end
        [75:87]: begin
          repeat ($urandom_range(1, 3)) send_cmd(tcs_pkg::REQ_READ, $urandom_range(0, 63));
        end
        default: begin
          r = {$urandom(), $urandom()};
          rq.kind = tcs_pkg::req_t'($urandom_range(0, 3));
          rq.side = tcs_pkg::ACC_W'($urandom());
          rq.fwd  = tcs_pkg::ACC_W'($urandom());
          rq.now  = ($urandom_range(0, 1)) ? r[tcs_pkg::TIME_BITS-1:0] : next_time();
          rq.pos  = tcs_pkg::POS_W'($urandom());
          send_request(rq);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_cmd(tcs_pkg::REQ_READ, 0);
    send_cmd(tcs_pkg::REQ_NOP, 0);
    send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    send_cmd(tcs_pkg::REQ_READ, 0);
    send_cmd(tcs_pkg::REQ_READ, 1);
    send_cmd(tcs_pkg::REQ_READ, 63);
    // strict compare at the start level, then held above the stop level
    send_tilt(1147, 0, 48'd1000);
    send_tilt(1148, 0, 48'd1000);
    send_tilt(738, 0, 48'd200000);
    send_tilt(738, 0, 48'd451000);
    send_tilt(737, 0, 48'd700000);
    send_tilt(-32768, 0, 48'd800000);
    send_tilt(32767, 0, 48'd800001);
    // forward jump to OK, held, then back tilt to DEL
    send_tilt(0, 1966, 48'd900000);
    send_tilt(0, 1967, 48'd900000);
    send_tilt(0, 1312, 48'd900001);
    send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    send_tilt(0, -32768, 48'd900002);
    send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    // step past OK and CANCEL and wrap at both ends
    send_tilt(-1148, 0, 48'd1000000);
    send_tilt(-1148, 0, 48'd1450000);
    send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    send_tilt(-1148, 0, 48'd1650000);
    send_tilt(1148, 0, 48'd1650001);
    send_tilt(0, 32767, 48'd1700000);
    // deadline wraps past the top of the time range
    send_tilt(-1148, 0, {tcs_pkg::TIME_BITS{1'b1}} - 48'd10);
    send_tilt(-1148, 0, 48'd5);
    stim_now = 48'd2000000;
  endtask

  task automatic test_store_full();
    send_tilt(0, 0, stim_now);
    while (sel_cursor >= tcs_pkg::IDX_DEL) begin
      send_tilt(-32768, 0, stim_now);
      send_tilt(0, 0, stim_now);
    end
    repeat (tcs_pkg::MAX_TEXT + 3) begin
      send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
      if ($urandom_range(0, 3) == 0) send_cmd(tcs_pkg::REQ_READ, $urandom_range(0, 63));
    end
    send_cmd(tcs_pkg::REQ_READ, tcs_pkg::MAX_TEXT - 1);
    send_cmd(tcs_pkg::REQ_READ, 63);
    send_tilt(0, -32768, stim_now);
    repeat (3) send_cmd(tcs_pkg::REQ_ACTIVATE, 0);
    send_cmd(tcs_pkg::REQ_READ, tcs_pkg::MAX_TEXT - 1);
    send_cmd(tcs_pkg::REQ_READ, tcs_pkg::MAX_TEXT - 4);
    send_tilt(0, 0, stim_now);
  endtask

  // Receiver holds off while requests keep coming, then the sender drains
  task automatic test_output_backpressure();
    hold_req++;
    no_gaps = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1)) send_tilt(near_level(sel_cfg.side_stop), 0, next_time());
      else send_cmd(tcs_pkg::REQ_READ, $urandom_range(0, 63));
    end
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  task automatic test_register_sweep();
    int lo;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings('0, '0, '0, '0, '0, '0);
        1: apply_settings('1, '1, '1, '1, '1, '1);
        2: apply_settings($urandom_range(0, 4000), $urandom_range(0, 4000),
                          $urandom_range(0, 4000), $urandom_range(0, 4000),
                          $urandom_range(0, 3000), $urandom_range(0, 3000));
        3: begin
          // stop level above start level
          lo = $urandom_range(0, 2000);
          apply_settings(lo, lo + $urandom_range(1, 3000), lo, lo + $urandom_range(1, 3000),
                         $urandom_range(0, 100000), $urandom_range(0, 100000));
        end
        4: apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
        5: apply_settings(tcs_pkg::SIDE_START_RST, tcs_pkg::SIDE_STOP_RST,
                          tcs_pkg::FWD_START_RST, tcs_pkg::FWD_STOP_RST,
                          tcs_pkg::FIRST_DLY_RST, tcs_pkg::REPEAT_RST);
        6: apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                          $urandom_range(0, 32767), $urandom_range(0, 32767),
                          $urandom_range(0, 16777215), $urandom_range(0, 16777215));
        default: apply_settings($urandom_range(0, 3000), $urandom_range(0, 3000),
                                $urandom_range(0, 3000), $urandom_range(0, 3000),
                                '0, '1);
      endcase
      if (phase == 4) hold_req++;
      run_random(230);
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    stall_mode_t mode;
    int mode_left;
    int period;
    int duty;
    int cyc;
    int hold_left;
    int hold_seen;
    mode      = STALL_NONE;
    mode_left = 0;
    period    = 2;
    duty      = 1;
    cyc       = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
        period    = $urandom_range(2, 9);
        duty      = $urandom_range(1, period - 1);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:   out_ch.ready <= 1'b1;
          STALL_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY:  out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:      out_ch.ready <= ((cyc % period) < duty);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    sel_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_selections.size() == 0) begin
        $display("%0t: result with nothing outstanding: cursor %0d action %0d char %0d",
                 $time, out_ch.cursor_index, out_ch.action, out_ch.char_code);
        errors++;
      end else begin
        want = pending_selections.pop_front();
        if (out_ch.moved !== want.moved) begin
          $display("%0t: moved expected %0d got %0d", $time, want.moved, out_ch.moved);
          errors++;
        end
        if (out_ch.cursor_index !== want.cursor) begin
          $display("%0t: cursor_index expected %0d got %0d", $time, want.cursor,
                   out_ch.cursor_index);
          errors++;
        end
        if (out_ch.action !== want.action) begin
          $display("%0t: action expected %0d got %0d", $time, want.action, out_ch.action);
          errors++;
        end
        if (out_ch.text_length !== want.len) begin
          $display("%0t: text_length expected %0d got %0d", $time, want.len,
                   out_ch.text_length);
          errors++;
        end
        if (out_ch.char_code !== want.ch) begin
          $display("%0t: char_code expected %0d got %0d", $time, want.ch, out_ch.char_code);
          errors++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, pending_selections.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= tcs_pkg::REQ_TILT;
    in_ch.side_accel    <= '0;
    in_ch.fwd_accel     <= '0;
    in_ch.now_us        <= '0;
    in_ch.read_position <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= tcs_pkg::CFG_SIDE_START;
    cfg_ch.wr_data      <= '0;
    sel_cfg.side_start    = tcs_pkg::SIDE_START_RST;
    sel_cfg.side_stop     = tcs_pkg::SIDE_STOP_RST;
    sel_cfg.fwd_start     = tcs_pkg::FWD_START_RST;
    sel_cfg.fwd_stop      = tcs_pkg::FWD_STOP_RST;
    sel_cfg.first_delay   = tcs_pkg::FIRST_DLY_RST;
    sel_cfg.repeat_period = tcs_pkg::REPEAT_RST;
    sel_cursor    = tcs_pkg::CURSOR_RST;
    sel_side_dir  = tcs_pkg::DIR_NONE;
    sel_fwd_dir   = tcs_pkg::DIR_NONE;
    sel_next_step = '0;
    sel_count     = '0;
    stim_now      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_store_full();
    test_output_backpressure();
    test_register_sweep();
    wait_for_results();

    if (pending_selections.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_selections.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d results, %0d register writes over 8 settings",
             items_sent, results_seen, cfg_writes);
    $display("Typematic repeat steps %0d, appends refused on a full store %0d, mismatches %0d",
             repeat_steps, full_refusals, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== tilt_cursor_selector.f =====
design/tcs_pkg.sv
design/tcs_if.sv
design/tcs_cfg_regs.sv
design/tcs_tilt.sv
design/tcs_text.sv
design/tilt_cursor_selector.sv
dv/tilt_cursor_selector_tb.sv
